// File: rtl/cbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chroma box downsampler package
// Shared sizes, register indexes and mode codes of the chroma box downsampler.
// ----------------------------------------------------------------------------
package cbd_pkg;

	// Largest frame the block is built for.
	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 4096;

	// Field widths of the ports.
	localparam int SAMPLE_W = 8;
	localparam int QUART_W  = 10;
	localparam int CFG_W    = 13;
	localparam int IDX_W    = 2;

	// Position counters and the upper-row store.
	localparam int COL_W      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int ROW_W      = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int PAIR_SLOTS = (MAX_WIDTH + 1) / 2;
	localparam int SLOT_W     = (PAIR_SLOTS > 1) ? $clog2(PAIR_SLOTS) : 1;
	localparam int HSUM_W     = SAMPLE_W + 1;

	// Width wide enough to compare positions against clamped sizes.
	localparam int CMP_A = (CFG_W > COL_W + 1) ? CFG_W : COL_W + 1;
	localparam int CMP_W = (CMP_A > ROW_W + 1) ? CMP_A : ROW_W + 1;

	// Register indexes of the configuration port.
	localparam logic [IDX_W-1:0] REG_SUB_MODE     = 2'd0;
	localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
	localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

	// Subsampling modes; the spare code behaves as 4:2:0.
	localparam logic [1:0] MODE_444   = 2'd0;
	localparam logic [1:0] MODE_420   = 2'd2;
	localparam logic [1:0] MODE_SPARE = 2'd3;

	// Reset values of the registers.
	localparam logic [CFG_W-1:0] RST_WIDTH  = 13'd640;
	localparam logic [CFG_W-1:0] RST_HEIGHT = 13'd480;

endpackage

// File: rtl/chroma_box_downsampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chroma box downsampler
// Reduces a raster chroma plane to 4:4:4, 4:2:2 or 4:2:0 by box averaging.
// ----------------------------------------------------------------------------
// Usage:
// Samples enter on the input channel (in_valid, in_stall, sample_in) in raster
// order from the top left. A transfer happens on a clock edge where valid is
// high and stall is low. Results leave on the output channel (out_valid,
// out_stall, avg_quarters, frame_end) as four times the group average, which
// is exact for groups of one, two or four samples. frame_end marks the last
// result of a frame. Registers are written through cfg_valid/cfg_ready with
// cfg_index and cfg_data; cfg_ready is always high. Write them only while
// the block is idle.
// Timing: an item is registered into stage one on acceptance and its result
// is formed there; the result of a sample that completes its group lands in
// the output register, raising out_valid, when that item moves on.
// One sample is accepted every cycle unless the input stalls; the upper-row
// store is read on acceptance and written as stage one moves on, with a bypass.
// A stall on the output holds the output register; the input stalls only
// when a finished result cannot move into that register.
// Reset clears the position counters, the pair register and the registers
// to their defaults (4:4:4, 640 x 480). The row store needs no clearing.
// ----------------------------------------------------------------------------
module chroma_box_downsampler (
	input  logic                          clk,
	input  logic                          arst_n,
	// Sample input channel.
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [cbd_pkg::SAMPLE_W-1:0]  sample_in,
	// Result output channel.
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [cbd_pkg::QUART_W-1:0]   avg_quarters,
	output logic                          frame_end,
	// Configuration write channel.
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [cbd_pkg::IDX_W-1:0]     cfg_index,
	input  logic [cbd_pkg::CFG_W-1:0]     cfg_data
);
	import cbd_pkg::*;

	// Configuration registers.
	logic [1:0]       sub_mode_q;
	logic [CFG_W-1:0] frame_width_q;
	logic [CFG_W-1:0] frame_height_q;

	// Position of the next sample and the first sample of a horizontal pair.
	logic [COL_W-1:0]    col_q;
	logic [ROW_W-1:0]    row_q;
	logic [SAMPLE_W-1:0] pair_hold_q;

	// Horizontal pair sums of the upper row of a 4:2:0 row pair.
	logic [HSUM_W-1:0] row_mem [PAIR_SLOTS];

	// Stage one: the accepted sample and what to do with it.
	logic                valid_s1;
	logic                emit_s1;
	logic                store_s1;
	logic                add_hold_s1;
	logic                add_row_s1;
	logic [1:0]          shift_s1;
	logic                last_s1;
	logic [SLOT_W-1:0]   slot_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic [SAMPLE_W-1:0] hold_s1;
	logic [HSUM_W-1:0]   rd_s1;
	logic                fwd_s1;
	logic [HSUM_W-1:0]   fwd_data_s1;

	// Output register.
	logic               out_valid_q;
	logic [QUART_W-1:0] avg_q;
	logic               frame_end_q;

	// Decode of the incoming sample.
	logic [CMP_W-1:0]  w_eff;
	logic [CMP_W-1:0]  h_eff;
	logic              last_col;
	logic              last_row;
	logic              horiz;
	logic              vert;
	logic              c_odd;
	logic              r_odd;
	logic              d_emit;
	logic              d_store;
	logic              d_hold;
	logic              d_add_hold;
	logic              d_add_row;
	logic [1:0]        d_shift;
	logic [SLOT_W-1:0] slot;

	// Handshake and datapath of stage one.
	logic              accept;
	logic              out_free;
	logic              fire_s1;
	logic [HSUM_W-1:0] hsum;
	logic [HSUM_W-1:0] row_val;
	logic [QUART_W-1:0] total;
	logic [QUART_W-1:0] quarters;

	assign cfg_ready = 1'b1;

	// Zero sizes act as one, oversize values act as the maximum.
	always_comb begin
		w_eff = CMP_W'(frame_width_q);
		if (frame_width_q == '0) begin
			w_eff = CMP_W'(1);
		end else if (CMP_W'(frame_width_q) > CMP_W'(MAX_WIDTH)) begin
			w_eff = CMP_W'(MAX_WIDTH);
		end
		h_eff = CMP_W'(frame_height_q);
		if (frame_height_q == '0) begin
			h_eff = CMP_W'(1);
		end else if (CMP_W'(frame_height_q) > CMP_W'(MAX_HEIGHT)) begin
			h_eff = CMP_W'(MAX_HEIGHT);
		end
	end

	// A position past the end of a shrunken frame counts as the last one.
	assign last_col = CMP_W'(col_q) >= (w_eff - CMP_W'(1));
	assign last_row = CMP_W'(row_q) >= (h_eff - CMP_W'(1));
	assign horiz    = sub_mode_q != MODE_444;
	assign vert     = (sub_mode_q == MODE_420) || (sub_mode_q == MODE_SPARE);
	assign c_odd    = col_q[0];
	assign r_odd    = row_q[0];
	assign slot     = SLOT_W'(col_q >> 1);

	// Decide whether this sample emits, parks an upper-row pair sum, or only
	// waits as the first half of a horizontal pair. The shift turns the group
	// sum into quarter units: by two for one sample, one for two, none for four.
	always_comb begin
		d_emit     = 1'b0;
		d_store    = 1'b0;
		d_hold     = 1'b0;
		d_add_hold = 1'b0;
		d_add_row  = 1'b0;
		d_shift    = 2'd2;
		if (!horiz) begin
			d_emit = 1'b1;
		end else if (!c_odd && !last_col) begin
			d_hold = 1'b1;
		end else begin
			d_add_hold = c_odd;
			if (!vert) begin
				d_emit  = 1'b1;
				d_shift = c_odd ? 2'd1 : 2'd2;
			end else if (!r_odd && !last_row) begin
				d_store = 1'b1;
			end else begin
				d_emit    = 1'b1;
				d_add_row = r_odd;
				if (c_odd && r_odd) begin
					d_shift = 2'd0;
				end else if (c_odd || r_odd) begin
					d_shift = 2'd1;
				end else begin
					d_shift = 2'd2;
				end
			end
		end
	end

	// A stage-one item moves on unless it has a result and the output
	// register is still full and stalled.
	assign out_free = !out_valid_q || !out_stall;
	assign fire_s1  = valid_s1 && (!emit_s1 || out_free);
	assign in_stall = valid_s1 && !fire_s1;
	assign accept   = in_valid && !in_stall;

	// The pair sum of the upper row comes from the store, or straight from
	// stage one when that item wrote the same slot in the cycle of the read.
	assign row_val  = fwd_s1 ? fwd_data_s1 : rd_s1;
	assign hsum     = HSUM_W'(sample_s1) + (add_hold_s1 ? HSUM_W'(hold_s1) : '0);
	assign total    = QUART_W'(hsum) + (add_row_s1 ? QUART_W'(row_val) : '0);
	assign quarters = QUART_W'(total << shift_s1);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_mode_q     <= MODE_444;
			frame_width_q  <= RST_WIDTH;
			frame_height_q <= RST_HEIGHT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SUB_MODE:     sub_mode_q     <= cfg_data[1:0];
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default:          ;
			endcase
		end
	end

	// Raster position and the held first sample of a pair.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			pair_hold_q <= '0;
		end else if (accept) begin
			if (d_hold) begin
				pair_hold_q <= sample_in;
			end
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : ROW_W'(row_q + ROW_W'(1));
			end else begin
				col_q <= COL_W'(col_q + COL_W'(1));
			end
		end
	end

	// Stage-one control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// Stage-one payload, including the registered read of the row store.
	always_ff @(posedge clk) begin
		if (accept) begin
			emit_s1     <= d_emit;
			store_s1    <= d_store;
			add_hold_s1 <= d_add_hold;
			add_row_s1  <= d_add_row;
			shift_s1    <= d_shift;
			last_s1     <= last_col && last_row;
			slot_s1     <= slot;
			sample_s1   <= sample_in;
			hold_s1     <= pair_hold_q;
			rd_s1       <= row_mem[slot];
			fwd_s1      <= valid_s1 && store_s1 && (slot_s1 == slot);
			fwd_data_s1 <= hsum;
		end
	end

	// Row store write of an upper-row pair sum.
	always_ff @(posedge clk) begin
		if (fire_s1 && store_s1) begin
			row_mem[slot_s1] <= hsum;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && emit_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && emit_s1) begin
			avg_q       <= quarters;
			frame_end_q <= last_s1;
		end
	end

	assign out_valid    = out_valid_q;
	assign avg_quarters = avg_q;
	assign frame_end    = frame_end_q;

endmodule

// File: test/tb_chroma_box_downsampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chroma box downsampler testbench
// Sends raster chroma samples through the block in all subsampling modes and
// checks every result against a cycle-free predictor of the box averages. The
// low slots of the row store are filled once, then directed frames cover
// partial groups, the spare mode code, zero sizes and mid-frame size changes.
// A long output hold-off fills the block, and random frames with oversize
// and ordinary sizes run under several idle and stall profiles.
// ----------------------------------------------------------------------------
module tb_chroma_box_downsampler;
	import cbd_pkg::*;

	// The package names no code for horizontal-only subsampling.
	localparam logic [1:0] MODE_422 = 2'd1;

	// Cycles to let pass after the last expected result before a register
	// write. A sample that completes no group may still be in the block.
	localparam int DRAIN_CYCLES = 6;
	// Random samples to send after the directed part.
	localparam int RANDOM_ITEMS = 700;
	// Columns covered by the row store fill. No lower row in this run reads
	// a column at or beyond this one.
	localparam int FILL_COLS = 64;
	// Hard stop for a hung run.
	localparam int CYCLE_LIMIT = 500000;

	// One result of the block: four times the group average and the end mark.
	typedef struct packed {
		logic [QUART_W-1:0] quarters;
		logic               frame_end;
	} avg_result_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	logic [SAMPLE_W-1:0]  sample_in = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [QUART_W-1:0]   avg_quarters;
	logic                 frame_end;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [IDX_W-1:0]     cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data  = '0;

	chroma_box_downsampler dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sample_in    (sample_in),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.avg_quarters (avg_quarters),
		.frame_end    (frame_end),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #4 clk = ~clk;

	// Shadow copy of the registers, as the block holds them after reset.
	logic [1:0]       mode_reg   = MODE_444;
	logic [CFG_W-1:0] width_reg  = RST_WIDTH;
	logic [CFG_W-1:0] height_reg = RST_HEIGHT;

	// Shadow copy of the block's position and averaging state.
	int unsigned      pos_col     = 0;
	int unsigned      pos_row     = 0;
	logic [7:0]       held_sample = '0;
	logic [HSUM_W-1:0] upper_sums [PAIR_SLOTS];

	// Results still owed by the block, oldest first.
	avg_result_t owed_results [$];

	// Idle behavior of both sides, changed from phase to phase.
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	// Cycles of forced output hold-off still to run.
	int holdoff_left   = 0;

	int mismatches      = 0;
	int samples_sent    = 0;
	int results_checked = 0;
	int frames_closed   = 0;
	int stalled_offers  = 0;
	int cycle_count     = 0;

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------

	// A size register of zero behaves as one; above the build maximum it
	// behaves as the maximum.
	function automatic int unsigned eff_size(input logic [CFG_W-1:0] v, input int unsigned maxv);
		if (v == 0)
			return 1;
		if (v > maxv)
			return maxv;
		return v;
	endfunction

	// Advances the shadow state by one accepted sample. Returns 1 when the
	// sample completes a group, with the group's result in res.
	function automatic bit box_average_step(input logic [7:0] s, output avg_result_t res);
		int unsigned w;
		int unsigned h;
		int unsigned hsum;
		int unsigned hcnt;
		int unsigned total;
		int unsigned cnt;
		int unsigned slot;
		bit          last_col;
		bit          last_row;
		bit          odd_col;
		bit          vert;
		bit          emit;

		w        = eff_size(width_reg, MAX_WIDTH);
		h        = eff_size(height_reg, MAX_HEIGHT);
		last_col = pos_col >= w - 1;
		last_row = pos_row >= h - 1;
		odd_col  = (pos_col & 1) != 0;
		vert     = (mode_reg == MODE_420) || (mode_reg == MODE_SPARE);
		emit     = 1'b0;
		total    = 0;
		cnt      = 1;

		if (mode_reg == MODE_444) begin
			emit  = 1'b1;
			total = s;
		end else if (!odd_col && !last_col) begin
			// First sample of a horizontal pair waits for its partner.
			held_sample = s;
		end else begin
			// A pair, or a lone sample in an odd last column.
			hsum = odd_col ? held_sample + s : s;
			hcnt = odd_col ? 2 : 1;
			slot = pos_col >> 1;
			if (!vert) begin
				emit  = 1'b1;
				total = hsum;
				cnt   = hcnt;
			end else if ((pos_row & 1) == 0 && !last_row) begin
				// Upper row of a row pair: keep the pair sum for the row below.
				upper_sums[slot] = hsum[HSUM_W-1:0];
			end else begin
				total = hsum;
				cnt   = hcnt;
				if ((pos_row & 1) != 0) begin
					total += upper_sums[slot];
					cnt   *= 2;
				end
				emit = 1'b1;
			end
		end

		res.quarters  = QUART_W'(total * 4 / cnt);
		res.frame_end = last_col && last_row;

		if (last_col) begin
			pos_col = 0;
			pos_row = last_row ? 0 : pos_row + 1;
		end else begin
			pos_col = pos_col + 1;
		end
		return emit;
	endfunction

	// ------------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------------

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("MISMATCH at cycle %0d after %0d results: %s got %0d want %0d",
			cycle_count, results_checked, what, got, want);
		mismatches++;
	endtask

	// Every output transfer is matched against the oldest owed result.
	always @(posedge clk) begin
		avg_result_t want;
		if (arst_n) begin
			if (in_valid && in_stall)
				stalled_offers++;
			if (out_valid && !out_stall) begin
				if (owed_results.size() == 0) begin
					report_mismatch("result with none owed, quarters", avg_quarters, 0);
				end else begin
					want = owed_results.pop_front();
					if (avg_quarters !== want.quarters)
						report_mismatch("avg_quarters", avg_quarters, want.quarters);
					if (frame_end !== want.frame_end)
						report_mismatch("frame_end", frame_end, want.frame_end);
				end
				if (frame_end === 1'b1)
					frames_closed++;
				results_checked++;
			end
		end
	end

	// The receiver stalls at random, or solidly while a hold-off is running.
	always @(posedge clk) begin
		if (holdoff_left != 0) begin
			out_stall    <= 1'b1;
			holdoff_left <= holdoff_left - 1;
		end else begin
			out_stall <= $urandom_range(0, 99) < recv_stall_pct;
		end
	end

	// Guard against a block that hangs or never drains.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results still owed",
				cycle_count, owed_results.size());
			$display("tb_chroma_box_downsampler failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	// Mostly uniform samples, with the extremes turning up often.
	function automatic logic [7:0] rand_sample();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Offers one sample, after a random idle gap, and holds it until the
	// transfer. Valid stays high on return so back-to-back samples run at
	// full rate.
	task automatic send_sample(input logic [7:0] s);
		avg_result_t res;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		sample_in <= s;
		do
			@(posedge clk);
		while (in_stall);
		if (box_average_step(s, res))
			owed_results.push_back(res);
		samples_sent++;
	endtask

	// Stops offering and waits until the block has nothing left in flight.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (owed_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Writes all three registers in one burst; the block must be idle.
	task automatic program_regs(input logic [1:0] mode, input logic [CFG_W-1:0] w,
			input logic [CFG_W-1:0] h);
		logic [IDX_W-1:0] idx  [3] = '{REG_SUB_MODE, REG_FRAME_WIDTH, REG_FRAME_HEIGHT};
		logic [CFG_W-1:0] vals [3];
		vals[0] = CFG_W'(mode);
		vals[1] = w;
		vals[2] = h;
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= vals[i];
			do
				@(posedge clk);
			while (!cfg_ready);
		end
		cfg_valid  <= 1'b0;
		mode_reg   = mode;
		width_reg  = w;
		height_reg = h;
	endtask

	// Brings the position back to the top left: with a 1 x 1 frame the next
	// sample is the last of its frame and the counters wrap.
	task automatic align_to_frame_start();
		if (pos_col != 0 || pos_row != 0) begin
			wait_drained();
			program_regs(mode_reg, 13'd1, 13'd1);
			send_sample(rand_sample());
		end
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Right after reset the block passes samples straight through at
	// 640 x 480, so none of these closes a frame.
	task automatic test_reset_defaults();
		logic [7:0] seq [4] = '{8'd0, 8'd255, 8'h55, 8'hAA};
		foreach (seq[i])
			send_sample(seq[i]);
	endtask

	// One 4:2:0 frame two rows high writes every slot of the row store that
	// a lower row can reach later on, so no later sequence reads a slot
	// that was never written.
	task automatic test_row_store_fill();
		align_to_frame_start();
		wait_drained();
		program_regs(MODE_420, CFG_W'(FILL_COLS), 13'd2);
		repeat (2 * FILL_COLS)
			send_sample(rand_sample());
	endtask

	// Short frames for each mode and special case.
	task automatic test_directed_cases();
		logic [7:0] pair_seq   [3] = '{8'd255, 8'd255, 8'd0};
		logic [7:0] square_seq [9] = '{8'd255, 8'd0, 8'd128,
		                               8'd1, 8'd254, 8'd7,
		                               8'd255, 8'd255, 8'd255};
		logic [7:0] spare_seq  [4] = '{8'd255, 8'd255, 8'd255, 8'd255};

		// 4:2:2 with an odd width: a full pair then a lone last column.
		wait_drained();
		program_regs(MODE_422, 13'd3, 13'd1);
		foreach (pair_seq[i])
			send_sample(pair_seq[i]);

		// 4:2:0 at 3 x 3: one full square, partial groups on the right
		// column and the bottom row, and a single corner sample.
		wait_drained();
		program_regs(MODE_420, 13'd3, 13'd3);
		foreach (square_seq[i])
			send_sample(square_seq[i]);

		// The spare mode code averages 2 x 2 like 4:2:0.
		wait_drained();
		program_regs(MODE_SPARE, 13'd2, 13'd2);
		foreach (spare_seq[i])
			send_sample(spare_seq[i]);

		// Zero sizes act as a 1 x 1 frame.
		wait_drained();
		program_regs(MODE_422, 13'd0, 13'd0);
		send_sample(8'd255);

		// Size change in the middle of a frame: the position stops at the
		// second row, second column of a 4 x 4 frame, then the frame shrinks
		// to 2 x 3 so that column is the last one and the next row is the
		// last one.
		wait_drained();
		program_regs(MODE_420, 13'd4, 13'd4);
		repeat (5) send_sample(rand_sample());
		wait_drained();
		program_regs(MODE_420, 13'd2, 13'd3);
		while (pos_col != 0 || pos_row != 0)
			send_sample(rand_sample());
	endtask

	// The receiver holds off for a long stretch while samples keep coming,
	// so the block fills up and stalls its input.
	task automatic test_output_holdoff();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		align_to_frame_start();
		wait_drained();
		program_regs(MODE_444, 13'd8, 13'd4);
		holdoff_left = 150;
		repeat (32) send_sample(rand_sample());
		wait_drained();
	endtask

	// Random settings under four idle profiles. Most phases start aligned
	// and send whole frames; the rest resize in mid frame and send a
	// random count. Wide frames always start aligned, so a lower row never
	// reaches past the filled columns.
	task automatic test_random_frames();
		int          sent;
		int          phase;
		int          n;
		int unsigned w_eff;
		int unsigned h_eff;
		logic [1:0]       mode;
		logic [CFG_W-1:0] w;
		logic [CFG_W-1:0] h;
		logic [CFG_W-1:0] wide_sizes [5] = '{13'd0, 13'd4095, 13'd4096, 13'd4097, 13'h1FFF};
		logic [CFG_W-1:0] tall_sizes [3] = '{13'd0, 13'd4096, 13'h1FFF};

		sent  = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			case (phase % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
				default: begin send_idle_pct = 16; recv_stall_pct = 16; end
			endcase

			mode = 2'($urandom_range(0, 3));
			case ($urandom_range(0, 19))
				0, 1, 2:   w = wide_sizes[$urandom_range(0, 4)];
				3, 4, 5:   w = CFG_W'($urandom_range(10, 40));
				default:   w = CFG_W'($urandom_range(1, 9));
			endcase
			case ($urandom_range(0, 19))
				0, 1:      h = tall_sizes[$urandom_range(0, 2)];
				default:   h = CFG_W'($urandom_range(1, 7));
			endcase
			w_eff = eff_size(w, MAX_WIDTH);
			h_eff = eff_size(h, MAX_HEIGHT);

			if ($urandom_range(0, 3) != 0 || w_eff > FILL_COLS)
				align_to_frame_start();

			wait_drained();
			program_regs(mode, w, h);

			if (pos_col == 0 && pos_row == 0 && w_eff * h_eff <= 120)
				n = $urandom_range(1, 3) * w_eff * h_eff;
			else
				n = $urandom_range(5, 60);
			repeat (n) send_sample(rand_sample());
			sent += n;
			phase++;
		end
	endtask

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------

	initial begin
		foreach (upper_sums[i])
			upper_sums[i] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_row_store_fill();
		test_directed_cases();
		test_output_holdoff();
		test_random_frames();

		// Let every owed result arrive, then watch a little longer for
		// anything extra.
		in_valid <= 1'b0;
		while (owed_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Covered %0d samples in all modes, %0d results checked, %0d frames closed.",
			samples_sent, results_checked, frames_closed);
		$display("Input stalled on %0d offered cycles; %0d mismatches.",
			stalled_offers, mismatches);
		if (mismatches == 0) begin
			$display("tb_chroma_box_downsampler passed");
		end else begin
			$display("tb_chroma_box_downsampler failed");
		end
		$finish;
	end

endmodule

// File: files.f
rtl/cbd_pkg.sv
rtl/chroma_box_downsampler.sv
test/tb_chroma_box_downsampler.sv
